// ----- sv/run_length_text_encoder_defines.svh -----
// Assertion macros shared by the run-length text encoder checker.
`ifndef RUN_LENGTH_TEXT_ENCODER_DEFINES_SVH
`define RUN_LENGTH_TEXT_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define RLTE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("run_length_text_encoder: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define RLTE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("run_length_text_encoder: next-cycle check failed");

`endif

// ----- sv/rlte_pkg.sv -----
// Types, constants and tables of the run-length text encoder.
package rlte_pkg;

	// Longest run that is counted; longer runs are reported at this length.
	localparam int MAX_RUN = 65535;

	// Width of the run counter.
	localparam int RUN_W = $clog2(MAX_RUN + 1);

	// Number of decimal digits needed for MAX_RUN.
	function automatic int count_digits();
		longint p;
		int n;
		p = 1;
		n = 0;
		while (p <= MAX_RUN) begin
			p = p * 10;
			n = n + 1;
		end
		return n;
	endfunction

	localparam int NDIG  = count_digits();
	localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;

	typedef logic [NDIG-1:0][RUN_W-1:0] pow_tab_t;

	// Powers of ten, one per digit position, entry 0 being one.
	function automatic pow_tab_t build_pow10();
		pow_tab_t t;
		longint p;
		p = 1;
		for (int i = 0; i < NDIG; i++) begin
			t[i] = RUN_W'(p);
			p = p * 10;
		end
		return t;
	endfunction

	localparam pow_tab_t POW10 = build_pow10();

	// Character codes.
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_Z  = 8'h7a;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} rlte_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_burst;
	} rlte_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_DIGIT,
		ST_SYMBOL
	} rlte_state_t;

endpackage

// ----- sv/run_length_text_encoder.sv -----
// Top level of the run-length text encoder: run tracking and digit sequencer.
//
// Usage: text bytes enter on the src channel (src_valid, src_stall, src_data), one
// byte per transaction, with end_of_string set on the final byte of a string.
// Letters are folded to lower case, other bytes are dropped. Encoded bytes leave
// on the dst channel (dst_valid, dst_stall, dst_data): the run length in decimal
// digits, most significant first and without leading zeros, then the symbol.
// last_of_burst marks the final byte caused by one input transaction.
// A byte that ends no run leaves src_stall low for the next byte. A byte that ends
// a run holds src_stall high while one compare-and-subtract unit walks the digit
// positions: per position it subtracts the power of ten once per unit of the digit,
// then hands the digit to the output register; the symbol comes last. A lone letter
// flushed by the same transaction is then encoded in the same way.
// The output register lets the sequencer continue while dst is stalled only if
// the register is free; otherwise the sequencer waits and src_stall stays high.
// Reset clears the pending run and the output valid; no clearing pass is needed.
module run_length_text_encoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  rlte_pkg::rlte_in_t  src_data,
	output logic              dst_valid,
	input  logic              dst_stall,
	output rlte_pkg::rlte_out_t dst_data
);
	import rlte_pkg::*;

	localparam logic [RUN_W-1:0] MAX_RUN_V = RUN_W'(MAX_RUN);
	localparam logic [IDX_W-1:0] IDX_TOP   = IDX_W'(NDIG - 1);
	localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);

	rlte_state_t      state_q, state_d;
	logic [7:0]       sym_q, sym_d;
	logic [RUN_W-1:0] len_q, len_d;
	logic [RUN_W-1:0] val_q, val_d;
	logic [7:0]       wsym_q, wsym_d;
	logic             sec_q, sec_d;
	logic [7:0]       sec_sym_q, sec_sym_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [3:0]       dig_q, dig_d;
	logic             started_q, started_d;
	logic             out_valid_q;
	rlte_out_t        out_q, out_next;
	logic             out_load;
	logic             slot_free;

	logic             is_upper, is_lower, letter, eos;
	logic [7:0]       b_fold;
	logic [RUN_W-1:0] len_inc;
	logic [RUN_W-1:0] pow_sel;

	// Input classification and case folding.
	assign eos      = src_data.end_of_string;
	assign is_upper = (src_data.in_byte >= CH_UPPER_A) && (src_data.in_byte <= CH_UPPER_Z);
	assign is_lower = (src_data.in_byte >= CH_LOWER_A) && (src_data.in_byte <= CH_LOWER_Z);
	assign letter   = is_upper || is_lower;
	assign b_fold   = is_upper ? (src_data.in_byte + CASE_OFFSET) : src_data.in_byte;

	// Saturating run length after one more equal letter.
	always_comb begin
		if (len_q == '0) begin
			len_inc = RUN_W'(1);
		end else if (len_q < MAX_RUN_V) begin
			len_inc = len_q + RUN_W'(1);
		end else begin
			len_inc = len_q;
		end
	end

	assign pow_sel   = POW10[idx_q];
	assign slot_free = !out_valid_q || !dst_stall;
	assign src_stall = (state_q != ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sym_q   <= '0;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			sym_q   <= sym_d;
			len_q   <= len_d;
		end
	end

	// Working registers of the digit sequencer.
	always_ff @(posedge clk) begin
		val_q     <= val_d;
		wsym_q    <= wsym_d;
		sec_q     <= sec_d;
		sec_sym_q <= sec_sym_d;
		idx_q     <= idx_d;
		dig_q     <= dig_d;
		started_q <= started_d;
	end

	// Next state, run tracking and the shared compare-and-subtract step.
	always_comb begin
		state_d   = state_q;
		sym_d     = sym_q;
		len_d     = len_q;
		val_d     = val_q;
		wsym_d    = wsym_q;
		sec_d     = sec_q;
		sec_sym_d = sec_sym_q;
		idx_d     = idx_q;
		dig_d     = dig_q;
		started_d = started_q;
		out_load  = 1'b0;
		out_next  = '0;
		case (state_q)
			ST_IDLE: begin
				if (src_valid) begin
					idx_d     = IDX_TOP;
					dig_d     = '0;
					started_d = 1'b0;
					if (letter && (len_q != '0) && (b_fold != sym_q)) begin
						// A different letter ends the pending run.
						val_d     = len_q;
						wsym_d    = sym_q;
						sec_d     = eos;
						sec_sym_d = b_fold;
						sym_d     = eos ? 8'h00 : b_fold;
						len_d     = eos ? '0 : RUN_W'(1);
						state_d   = ST_CONV;
					end else if (letter) begin
						if (eos) begin
							val_d   = len_inc;
							wsym_d  = b_fold;
							sec_d   = 1'b0;
							sym_d   = 8'h00;
							len_d   = '0;
							state_d = ST_CONV;
						end else begin
							sym_d = b_fold;
							len_d = len_inc;
						end
					end else if (eos) begin
						// Dropped byte that still closes the string.
						sym_d = 8'h00;
						len_d = '0;
						if (len_q != '0) begin
							val_d   = len_q;
							wsym_d  = sym_q;
							sec_d   = 1'b0;
							state_d = ST_CONV;
						end
					end
				end
			end
			ST_CONV: begin
				if (val_q >= pow_sel) begin
					val_d = val_q - pow_sel;
					dig_d = dig_q + 4'd1;
				end else if (started_q || (dig_q != 4'd0) || (idx_q == '0)) begin
					state_d = ST_DIGIT;
				end else begin
					// Leading zero: skip to the next position.
					idx_d = idx_q - IDX_ONE;
				end
			end
			ST_DIGIT: begin
				if (slot_free) begin
					out_load               = 1'b1;
					out_next.out_byte      = CH_ZERO + {4'b0000, dig_q};
					out_next.last_of_burst = 1'b0;
					started_d              = 1'b1;
					dig_d                  = '0;
					if (idx_q == '0) begin
						state_d = ST_SYMBOL;
					end else begin
						idx_d   = idx_q - IDX_ONE;
						state_d = ST_CONV;
					end
				end
			end
			ST_SYMBOL: begin
				if (slot_free) begin
					out_load               = 1'b1;
					out_next.out_byte      = wsym_q;
					out_next.last_of_burst = !sec_q;
					if (sec_q) begin
						// A lone letter that also ended the string follows.
						val_d     = RUN_W'(1);
						wsym_d    = sec_sym_q;
						sec_d     = 1'b0;
						idx_d     = IDX_TOP;
						dig_d     = '0;
						started_d = 1'b0;
						state_d   = ST_CONV;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

endmodule

// ----- sv/rlte_checker.sv -----
// Port-level checker for the run-length text encoder and its bind statement.
`include "run_length_text_encoder_defines.svh"

module rlte_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              src_valid,
	input logic              src_stall,
	input rlte_pkg::rlte_in_t  src_data,
	input logic              dst_valid,
	input logic              dst_stall,
	input rlte_pkg::rlte_out_t dst_data
);
	import rlte_pkg::*;

	// A stalled result stays offered.
	`RLTE_ASSERT_NEXT(a_dst_hold, dst_valid && dst_stall, dst_valid)

	// A stalled result keeps its payload.
	`RLTE_ASSERT_NEXT(a_dst_stable, dst_valid && dst_stall, $stable(dst_data))

	// A dropped byte that does not end the string never makes the block busy.
	`RLTE_ASSERT_NEXT(a_drop_ready,
		src_valid && !src_stall && !src_data.end_of_string &&
		!((src_data.in_byte >= CH_LOWER_A) && (src_data.in_byte <= CH_LOWER_Z)) &&
		!((src_data.in_byte >= CH_UPPER_A) && (src_data.in_byte <= CH_UPPER_Z)),
		!src_stall)

	// A burst always closes with a lower-case symbol, never a digit.
	`RLTE_ASSERT_SAME(a_last_is_symbol, dst_valid && dst_data.last_of_burst,
		(dst_data.out_byte >= CH_LOWER_A) && (dst_data.out_byte <= CH_LOWER_Z))

endmodule

bind run_length_text_encoder rlte_checker u_rlte_checker (.*);

// ----- dv/tb_run_length_text_encoder.sv -----
// Self-checking testbench for the run-length text encoder, with a predictor and random flow control.
`timescale 1ns / 1ps

module tb_run_length_text_encoder;
	import rlte_pkg::*;

	localparam int RANDOM_ITEMS = 430;
	localparam int HOLD_AFTER   = 100;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 3000000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	rlte_in_t  src_data  = '0;
	logic      dst_valid;
	logic      dst_stall = 1'b0;
	rlte_out_t dst_data;

	// Text bytes still to be offered, and encoded bytes still to come out.
	rlte_in_t  text_q[$];
	rlte_out_t encoded_bytes_q[$];

	// Predicted run state.
	logic [7:0] pend_sym = '0;
	int         pend_len = 0;

	int error_count    = 0;
	int accepted_count = 0;
	int cycle_count    = 0;

	// Sender burst and gap counters, receiver pattern and hold-off.
	int burst_left     = 1;
	int gap_left       = 0;
	int stall_run_left = 0;
	bit stall_on       = 1'b0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;

	rlte_out_t next_encoded;

	run_length_text_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	always #5 clk = ~clk;

	function automatic bit is_alpha(input logic [7:0] b);
		return (b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b >= CH_UPPER_A && b <= CH_UPPER_Z);
	endfunction

	function automatic logic [7:0] random_letter(input int idx);
		logic [7:0] ch;
		ch = CH_LOWER_A + 8'(idx);
		if ($urandom_range(0, 1) == 0) begin
			ch = ch - CASE_OFFSET;
		end
		return ch;
	endfunction

	function automatic logic [7:0] random_non_letter();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (is_alpha(b));
		return b;
	endfunction

	task automatic push_text(input logic [7:0] b, input logic eos);
		rlte_in_t t;
		t.in_byte       = b;
		t.end_of_string = eos;
		text_q.push_back(t);
	endtask

	// Queue the pending run as decimal count digits, most significant first, then the symbol.
	function automatic void queue_run();
		int         v;
		logic [7:0] digs[$];
		rlte_out_t  r;
		v = pend_len;
		do begin
			digs.push_front(CH_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		r.last_of_burst = 1'b0;
		foreach (digs[i]) begin
			r.out_byte = digs[i];
			encoded_bytes_q.push_back(r);
		end
		r.out_byte = pend_sym;
		encoded_bytes_q.push_back(r);
	endfunction

	// Work out the encoded bytes that one accepted text byte causes.
	function automatic void encode_text_byte(input rlte_in_t item);
		logic [7:0] ch;
		int         first;
		rlte_out_t  tail;
		ch    = item.in_byte;
		first = encoded_bytes_q.size();
		if (is_alpha(ch)) begin
			if (ch <= CH_UPPER_Z) begin
				ch = ch + CASE_OFFSET;
			end
			if (pend_len != 0 && ch != pend_sym) begin
				queue_run();
				pend_len = 0;
			end
			if (pend_len == 0) begin
				pend_sym = ch;
				pend_len = 1;
			end else if (pend_len < MAX_RUN) begin
				pend_len++;
			end
		end
		if (item.end_of_string) begin
			if (pend_len != 0) begin
				queue_run();
			end
			pend_len = 0;
			pend_sym = '0;
		end
		if (encoded_bytes_q.size() > first) begin
			tail = encoded_bytes_q.pop_back();
			tail.last_of_burst = 1'b1;
			encoded_bytes_q.push_back(tail);
		end
	endfunction

	// Driver: predicts each accepted transaction and offers the next byte in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_data  <= '0;
		end else begin
			if (src_valid && !src_stall) begin
				encode_text_byte(src_data);
				accepted_count <= accepted_count + 1;
			end
			if (!src_valid || !src_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					src_valid <= 1'b0;
				end else if (text_q.size() != 0) begin
					src_data  <= text_q.pop_front();
					src_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// One long hold-off on the output once traffic is under way, so the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver stall pattern: short stall runs between pass runs, some of them long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_stall      <= 1'b0;
			stall_on       = 1'b0;
			stall_run_left = 0;
		end else begin
			if (stall_run_left == 0) begin
				stall_on = !stall_on;
				if (stall_on) begin
					stall_run_left = $urandom_range(1, 12);
				end else begin
					stall_run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 8);
				end
			end
			stall_run_left--;
			dst_stall <= stall_on || (hold_left != 0);
		end
	end

	// Monitor: compare each output transaction with the oldest predicted byte.
	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			if (encoded_bytes_q.size() == 0) begin
				$error("out_byte: expected nothing, got %h", dst_data.out_byte);
				error_count++;
			end else begin
				next_encoded = encoded_bytes_q.pop_front();
				if (dst_data.out_byte !== next_encoded.out_byte) begin
					$error("out_byte: expected %h, got %h", next_encoded.out_byte,
						dst_data.out_byte);
					error_count++;
				end
				if (dst_data.last_of_burst !== next_encoded.last_of_burst) begin
					$error("last_of_burst: expected %b, got %b", next_encoded.last_of_burst,
						dst_data.last_of_burst);
					error_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_run_length_text_encoder: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		int         nruns;
		int         len;
		int         sel;
		int         sym;
		int         wait_cycles;
		bit         eos_on_letter;
		logic [7:0] ch;

		// Case folding, a run ended by a different letter, and a run closed by the end mark.
		push_text("A", 1'b0);
		push_text("a", 1'b0);
		push_text("a", 1'b0);
		push_text("z", 1'b0);
		push_text("Z", 1'b1);
		// A non-letter carrying the end mark still flushes the run.
		push_text("Q", 1'b0);
		push_text("q", 1'b0);
		push_text("!", 1'b1);
		// End marks with nothing pending emit nothing.
		push_text("5", 1'b1);
		push_text(8'h00, 1'b1);
		// A final letter that differs flushes two runs in one transaction.
		push_text("m", 1'b0);
		push_text("K", 1'b1);
		// Bytes just outside the letter ranges are dropped without breaking the run.
		push_text("b", 1'b0);
		push_text(8'h40, 1'b0);
		push_text("B", 1'b0);
		push_text(8'h5B, 1'b0);
		push_text(8'h60, 1'b0);
		push_text(8'h7B, 1'b0);
		push_text(8'hFF, 1'b0);
		push_text(8'h80, 1'b0);
		push_text("b", 1'b1);

		// Random strings: runs of random letters and lengths, with noise bytes mixed in.
		while (text_q.size() < RANDOM_ITEMS) begin
			nruns         = $urandom_range(0, 6);
			eos_on_letter = (nruns != 0) && ($urandom_range(0, 3) != 0);
			for (int r = 0; r < nruns; r++) begin
				sel = $urandom_range(0, 99);
				if (sel < 65) begin
					len = $urandom_range(1, 4);
				end else if (sel < 88) begin
					len = $urandom_range(5, 15);
				end else if (sel < 98) begin
					len = $urandom_range(16, 120);
				end else begin
					len = $urandom_range(121, 400);
				end
				// Keep the total close to the item budget.
				if (text_q.size() + len > RANDOM_ITEMS + 20) begin
					len = 1;
				end
				sym = $urandom_range(0, 25);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) == 0) begin
						push_text(random_non_letter(), 1'b0);
					end
					ch = random_letter(sym);
					push_text(ch, eos_on_letter && (r == nruns - 1) && (i == len - 1));
				end
			end
			if (!eos_on_letter) begin
				push_text(random_non_letter(), 1'b1);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (text_q.size() != 0 || src_valid) begin
			@(posedge clk);
		end
		wait_cycles = 0;
		while (encoded_bytes_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (encoded_bytes_q.size() != 0) begin
			$error("out_byte: %0d predicted bytes never arrived", encoded_bytes_q.size());
			error_count++;
		end

		if (error_count == 0) begin
			$display("tb_run_length_text_encoder: done, clean");
		end else begin
			$display("tb_run_length_text_encoder: done, errors");
		end
		$finish;
	end

endmodule
